// ----- rtl/b58enc_pkg.sv -----
package b58enc_pkg;

  // Fixed field and state widths.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CARRY_W     = 8;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned MAX_RESULTS = 44;
  localparam int unsigned LEFT_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ONE  = 7'h31;
  localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;
  } b58enc_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic              overflow;
  } b58enc_out_t;

  // Controls broadcast to every digit cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } b58enc_cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_SKIP,
    ST_EMIT,
    ST_OVF
  } b58enc_state_e;

  // Maps a base-58 digit to its character in the Bitcoin alphabet.
  function automatic logic [CHAR_W-1:0] b58enc_char(input logic [DIGIT_W-1:0] digit);
    logic [CHAR_W-1:0] ch;
    if (digit < 6'd9) begin
      ch = 7'h31 + CHAR_W'(digit);
    end else if (digit < 6'd17) begin
      ch = 7'h41 + CHAR_W'(digit - 6'd9);
    end else if (digit < 6'd22) begin
      ch = 7'h4A + CHAR_W'(digit - 6'd17);
    end else if (digit < 6'd33) begin
      ch = 7'h50 + CHAR_W'(digit - 6'd22);
    end else if (digit < 6'd44) begin
      ch = 7'h61 + CHAR_W'(digit - 6'd33);
    end else if (digit < 6'd58) begin
      ch = 7'h6D + CHAR_W'(digit - 6'd44);
    end else begin
      ch = CHAR_NONE;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/b58enc_cell.sv -----
module b58enc_cell
  import b58enc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  b58enc_cell_ctl_t       ctl_i,
  input  logic                   fold_i,
  input  logic [CARRY_W-1:0]     carry_i,
  input  logic [DIGIT_W-1:0]     next_digit_i,
  output logic [DIGIT_W-1:0]     digit_o,
  output logic                   fold_o,
  output logic [CARRY_W-1:0]     carry_o
);

  // Quotient and remainder of 256 * d by 58 for d below 29, packed {q, r}.
  // Above that the pattern repeats with the quotient raised by 128.
  function automatic logic [13:0] mul256_div58(input logic [4:0] d);
    logic [13:0] v;
    case (d)
      5'd0:    v = {8'd0,   6'd0};
      5'd1:    v = {8'd4,   6'd24};
      5'd2:    v = {8'd8,   6'd48};
      5'd3:    v = {8'd13,  6'd14};
      5'd4:    v = {8'd17,  6'd38};
      5'd5:    v = {8'd22,  6'd4};
      5'd6:    v = {8'd26,  6'd28};
      5'd7:    v = {8'd30,  6'd52};
      5'd8:    v = {8'd35,  6'd18};
      5'd9:    v = {8'd39,  6'd42};
      5'd10:   v = {8'd44,  6'd8};
      5'd11:   v = {8'd48,  6'd32};
      5'd12:   v = {8'd52,  6'd56};
      5'd13:   v = {8'd57,  6'd22};
      5'd14:   v = {8'd61,  6'd46};
      5'd15:   v = {8'd66,  6'd12};
      5'd16:   v = {8'd70,  6'd36};
      5'd17:   v = {8'd75,  6'd2};
      5'd18:   v = {8'd79,  6'd26};
      5'd19:   v = {8'd83,  6'd50};
      5'd20:   v = {8'd88,  6'd16};
      5'd21:   v = {8'd92,  6'd40};
      5'd22:   v = {8'd97,  6'd6};
      5'd23:   v = {8'd101, 6'd30};
      5'd24:   v = {8'd105, 6'd54};
      5'd25:   v = {8'd110, 6'd20};
      5'd26:   v = {8'd114, 6'd44};
      5'd27:   v = {8'd119, 6'd10};
      5'd28:   v = {8'd123, 6'd34};
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic               fold_q;
  logic [CARRY_W-1:0] carry_q, carry_d;

  logic               hi;
  logic [4:0]         dl;
  logic [13:0]        tab;
  logic [7:0]         qd;
  logic [5:0]         rd;
  logic [8:0]         t;
  logic [2:0]         q2;
  logic [DIGIT_W-1:0] r2;

  // digit * 256 + carry split into a table part and a small remainder
  // that stays below six times 58, so its quotient is at most five.
  always_comb begin
    hi  = (digit_q >= 6'd29);
    dl  = hi ? 5'(digit_q - 6'd29) : 5'(digit_q);
    tab = mul256_div58(dl);
    qd  = tab[13:6] + (hi ? 8'd128 : 8'd0);
    rd  = tab[5:0];
    t   = 9'(rd) + 9'(carry_i);
    q2  = 3'(t >= 9'd58) + 3'(t >= 9'd116) + 3'(t >= 9'd174)
        + 3'(t >= 9'd232) + 3'(t >= 9'd290);
    r2  = DIGIT_W'(t - 9'(q2) * 9'd58);
    carry_d = qd + 8'(q2);
  end

  always_comb begin
    digit_d = digit_q;
    if (ctl_i.clear) begin
      digit_d = '0;
    end else if (fold_i) begin
      digit_d = r2;
    end else if (ctl_i.shift) begin
      digit_d = next_digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      fold_q  <= 1'b0;
    end else begin
      digit_q <= digit_d;
      fold_q  <= fold_i;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  assign digit_o = digit_q;
  assign fold_o  = fold_q;
  assign carry_o = carry_q;

endmodule

// ----- rtl/base58_encoder.sv -----
// Base58 encoder (Bitcoin alphabet) taking one byte per input transfer,
// most significant byte first, with final_byte set on the last one. The
// base-58 value is held in a row of DIGITS digit cells; a byte is folded
// in by a carry wave that enters the least significant cell and moves one
// cell per clock; the input is not ready again until the wave has passed
// the whole row. Leading zero bytes and bytes past the MAX_BYTES limit are
// taken without a fold. After the final byte the row shifts out leading
// zero digits, one per cycle, then emits one '1' per leading zero byte
// followed by the significant digits, one character per cycle while the
// output side takes them; out_last marks the last character. A
// string longer than MAX_BYTES yields a single transfer with overflow set
// and out_char zero. All string state is cleared once the last result has
// been loaded into the output register, and the next string may start at
// once, even while that result still waits to be taken.
module base58_encoder
  import b58enc_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 32,
  parameter int unsigned DIGITS    = 44
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  b58enc_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output b58enc_out_t out_data_o
);

  localparam int unsigned RW = $clog2(DIGITS + 1);
  localparam int unsigned TW = ((RW > CNT_W) ? RW : CNT_W) + 1;
  localparam logic [CNT_W-1:0] MaxBytesC = CNT_W'(MAX_BYTES);

  b58enc_state_e state_q, state_d;

  logic [CNT_W-1:0]  byte_count_q;
  logic [CNT_W-1:0]  zero_count_q;
  logic              seen_q;
  logic              too_long_q;
  logic              fin_q;
  logic [RW-1:0]     cnt_q;
  logic [RW-1:0]     rem_q;
  logic [LEFT_W-1:0] left_q;
  logic [LEFT_W-1:0] left_init;
  logic [TW-1:0]     total;

  logic              out_valid_q;
  b58enc_out_t       out_q;
  b58enc_out_t       out_next;
  logic              out_free;
  logic              out_load;
  logic              out_ovf;

  logic              accept;
  logic              limit_hit;
  logic              take;
  logic              lead_zero;
  logic              do_fold;
  logic              skip_stop;

  b58enc_cell_ctl_t  cell_ctl;

  // Chain wires: index j is driven by cell j, index DIGITS feeds the tail.
  logic [DIGIT_W-1:0] digit_w [DIGITS+1];
  logic               fold_w  [DIGITS+1];
  logic [CARRY_W-1:0] carry_w [DIGITS+1];

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  // Classification of the byte on offer. Once the limit is reached, a
  // further byte marks the string too long and is dropped.
  assign limit_hit = (byte_count_q >= MaxBytesC);
  assign take      = !too_long_q && !limit_hit;
  assign lead_zero = take && !seen_q && (in_data_i.data_byte == '0);
  assign do_fold   = take && !lead_zero;

  // Leading zero digits are skipped until a nonzero digit reaches the head
  // of the row or the row is exhausted, and not at all if no byte was folded.
  assign skip_stop = !seen_q || (rem_q == '0) || (digit_w[0] != '0);
  assign total     = TW'(zero_count_q) + (seen_q ? TW'(rem_q) : TW'(0));
  assign left_init = (total > TW'(MAX_RESULTS)) ? LEFT_W'(MAX_RESULTS) : LEFT_W'(total);

  // The carry wave enters the least significant cell on the accepting edge.
  assign fold_w[DIGITS]  = accept && do_fold;
  assign carry_w[DIGITS] = in_data_i.data_byte;
  assign digit_w[DIGITS] = '0;

  for (genvar j = 0; j < DIGITS; j++) begin : g_cell
    b58enc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl),
      .fold_i       (fold_w[j+1]),
      .carry_i      (carry_w[j+1]),
      .next_digit_i (digit_w[j+1]),
      .digit_o      (digit_w[j]),
      .fold_o       (fold_w[j]),
      .carry_o      (carry_w[j])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (do_fold) begin
            state_d = ST_FOLD;
          end else if (in_data_i.final_byte) begin
            state_d = (too_long_q || limit_hit) ? ST_OVF : ST_SKIP;
          end
        end
      end
      ST_FOLD: begin
        if (cnt_q == RW'(1)) begin
          state_d = fin_q ? ST_SKIP : ST_IDLE;
        end
      end
      ST_SKIP: begin
        if (skip_stop) begin
          state_d = (total == '0) ? ST_IDLE : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (left_q == LEFT_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o     = 1'b0;
    cell_ctl.shift = 1'b0;
    cell_ctl.clear = 1'b0;
    out_load       = 1'b0;
    out_ovf        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_FOLD: begin
      end
      ST_SKIP: begin
        cell_ctl.shift = !skip_stop;
        cell_ctl.clear = skip_stop && (total == '0);
      end
      ST_EMIT: begin
        out_load       = out_free;
        cell_ctl.shift = out_free && (zero_count_q == '0);
        cell_ctl.clear = out_free && (left_q == LEFT_W'(1));
      end
      ST_OVF: begin
        out_load       = out_free;
        out_ovf        = 1'b1;
        cell_ctl.clear = out_free;
      end
      default: begin
      end
    endcase
  end

  // Result word: zero out_char with overflow set in ST_OVF; otherwise '1'
  // characters for leading zero bytes first, then the head digit of the row.
  always_comb begin
    if (out_ovf) begin
      out_next.out_char = CHAR_NONE;
      out_next.out_last = 1'b1;
      out_next.overflow = 1'b1;
    end else begin
      out_next.out_char = (zero_count_q != '0) ? CHAR_ONE : b58enc_char(digit_w[0]);
      out_next.out_last = (left_q == LEFT_W'(1));
      out_next.overflow = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      byte_count_q <= '0;
      zero_count_q <= '0;
      seen_q       <= 1'b0;
      too_long_q   <= 1'b0;
      fin_q        <= 1'b0;
      cnt_q        <= '0;
      rem_q        <= '0;
      left_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (accept) begin
        fin_q <= in_data_i.final_byte;
        if (take) begin
          byte_count_q <= byte_count_q + CNT_W'(1);
        end
        if (lead_zero) begin
          zero_count_q <= zero_count_q + CNT_W'(1);
        end
        if (do_fold) begin
          seen_q <= 1'b1;
          cnt_q  <= RW'(DIGITS - 1);
        end
        if (limit_hit) begin
          too_long_q <= 1'b1;
        end
      end

      if (state_q == ST_FOLD) begin
        cnt_q <= cnt_q - RW'(1);
      end

      if ((state_d == ST_SKIP) && (state_q != ST_SKIP)) begin
        rem_q <= RW'(DIGITS);
      end else if (cell_ctl.shift && (state_q == ST_SKIP)) begin
        rem_q <= rem_q - RW'(1);
      end

      if ((state_q == ST_SKIP) && (state_d == ST_EMIT)) begin
        left_q <= left_init;
      end else if ((state_q == ST_EMIT) && out_load) begin
        left_q <= left_q - LEFT_W'(1);
        if (zero_count_q != '0) begin
          zero_count_q <= zero_count_q - CNT_W'(1);
        end
      end

      // End of string: counts and seen/too_long flags go back to reset.
      if (cell_ctl.clear) begin
        byte_count_q <= '0;
        zero_count_q <= '0;
        seen_q       <= 1'b0;
        too_long_q   <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
